// ===== design/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge out of reset.
`define AST_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define AST_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/asa_pkg.sv =====
// Types, codes and constants of the aligned stack allocator.
`default_nettype none

package asa_pkg;

  localparam int ADDR_W = 48;
  localparam int SIZE_W = 32;
  // Address arithmetic width: 48-bit base plus 32-bit offset plus padding.
  localparam int CALC_W = 50;

  localparam int MAX_FRAMES_DEF = 256;
  localparam int HEADER_BYTES   = 56;
  // Both alignments are powers of two.
  localparam int MIN_ALIGN      = 8;
  localparam int HDR_ALIGN      = 8;

  localparam logic [SIZE_W-1:0] CAPACITY_RST = 32'd65536;

  // Request modes
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NO_MEM  = 3'd1;
  localparam logic [2:0] ST_ZERO    = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_NOT_TOP = 3'd4;
  localparam logic [2:0] ST_EMPTY   = 3'd5;

  // Register select: paddr bit 3 (registers sit 8 bytes apart)
  localparam int         CFG_ADDR_W    = 4;
  localparam int         CFG_DATA_W    = 64;
  localparam logic       REG_BASE_ADDR = 1'b0;
  localparam logic       REG_CAPACITY  = 1'b1;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SIZE_W-1:0] alloc_bytes;
    logic [3:0]        align_log2;
    logic [ADDR_W-1:0] release_address;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] data_address;
    logic [SIZE_W-1:0] frame_bytes;
    logic [SIZE_W-1:0] used_bytes;
  } out_word_t;

  typedef struct packed {
    logic [SIZE_W-1:0] start;  // used offset before the frame
    logic [SIZE_W-1:0] data;   // data offset from the base address
  } frame_rec_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stack_cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base_address;
    logic [SIZE_W-1:0] capacity;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/asa_cfg_regs.sv =====
// APB-style configuration registers of the allocator.
`default_nettype none

module asa_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [asa_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [asa_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [asa_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                  pready,
  output asa_pkg::cfg_t                         cfg
);

  asa_pkg::cfg_t cfg_r, cfg_nxt;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  // Byte offset bits below bit 3 are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[3])
        asa_pkg::REG_BASE_ADDR: cfg_nxt.base_address = pwdata[asa_pkg::ADDR_W-1:0];
        asa_pkg::REG_CAPACITY:  cfg_nxt.capacity     = pwdata[asa_pkg::SIZE_W-1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      asa_pkg::REG_BASE_ADDR: prdata = asa_pkg::CFG_DATA_W'(cfg_r.base_address);
      asa_pkg::REG_CAPACITY:  prdata = asa_pkg::CFG_DATA_W'(cfg_r.capacity);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_address <= '0;
      cfg_r.capacity     <= asa_pkg::CAPACITY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/asa_frame_stack.sv =====
// Frame record stack: top record in flops, deeper records in a memory.
`default_nettype none

`include "assert_macros.svh"

module asa_frame_stack #(
  parameter int MAX_FRAMES = asa_pkg::MAX_FRAMES_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire asa_pkg::stack_cmd_t                    cmd,
  input  wire asa_pkg::frame_rec_t                    push_rec,
  output logic [$clog2(MAX_FRAMES+1)-1:0]             count,
  output asa_pkg::frame_rec_t                         top_rec
);

  localparam int CNTW  = $clog2(MAX_FRAMES + 1);
  localparam int AW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int DEPTH = 1 << AW;

  logic [CNTW-1:0]     count_r, count_nxt;
  logic [CNTW-1:0]     cnt_m1, cnt_nxt_m2;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic                wr_en;
  logic                fwd_r;
  asa_pkg::frame_rec_t top_r, top_nxt;
  asa_pkg::frame_rec_t rd_rec_r, fwd_rec_r, below;
  asa_pkg::frame_rec_t mem [DEPTH];

  // Record just under the top: memory read of count-2, or the record
  // that was pushed down in the previous cycle.
  assign below   = fwd_r ? fwd_rec_r : rd_rec_r;
  assign count   = count_r;
  assign top_rec = top_r;

  always_comb begin
    count_nxt = count_r;
    top_nxt   = top_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.push) begin
      count_nxt = count_r + CNTW'(1);
      top_nxt   = push_rec;
    end else if (cmd.pop) begin
      count_nxt = count_r - CNTW'(1);
      top_nxt   = below;
    end
  end

  // Push sinks the old top into the memory at count-1.
  assign cnt_m1     = count_r - CNTW'(1);
  assign wr_addr    = cnt_m1[AW-1:0];
  assign wr_en      = cmd.push && (count_r != '0);
  assign cnt_nxt_m2 = count_nxt - CNTW'(2);
  assign rd_addr    = cnt_nxt_m2[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= top_r;
    end
    rd_rec_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      fwd_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      fwd_r   <= wr_en;
    end
    top_r     <= top_nxt;
    fwd_rec_r <= top_r;
  end

  `AST_ALWAYS(a_cmd_excl, $onehot0({cmd.push, cmd.pop, cmd.clear}), "stack commands overlap")
  `AST_ALWAYS(a_cnt_bound, count_r <= CNTW'(MAX_FRAMES), "record count above depth")
  `AST_NEXT(a_pop_cnt, cmd.pop, count_r == $past(count_r) - CNTW'(1), "pop count mismatch")

endmodule

`default_nettype wire

// ===== design/aligned_stack_allocator.sv =====
// Top level of the aligned LIFO stack allocator.
// Accepts one request word per clock unless the result channel stalls, and
// returns one result word for each: a request is captured in the input
// register, worked by the address logic (marker round-up to 8, header add,
// align round-up, capacity compare, top-frame compare), and the result lands
// in the output register. The input register stalls only while it holds a
// request and the result register stalls; when empty it takes a new request
// while a finished result waits downstream. Frame records live in a small
// stack: the top record sits in flops, deeper records in a memory whose next
// entry is prefetched, so pops issue back to back too. Registers: base_address
// at byte 0 and capacity at byte 8 (64-bit data); write them only while the
// block is idle. Reset empties the stack and needs no clearing pass.
`default_nettype none

`include "assert_macros.svh"

module aligned_stack_allocator #(
  parameter int MAX_FRAMES = asa_pkg::MAX_FRAMES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // request channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire asa_pkg::in_word_t                  in_data,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output asa_pkg::out_word_t                      out_data,
  // configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [asa_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [asa_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [asa_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                    pready
);

  localparam int CNTW   = $clog2(MAX_FRAMES + 1);
  localparam int CALC_W = asa_pkg::CALC_W;
  localparam int ADDR_W = asa_pkg::ADDR_W;
  localparam int SIZE_W = asa_pkg::SIZE_W;

  asa_pkg::cfg_t        cfg;
  asa_pkg::stack_cmd_t  cmd;
  asa_pkg::frame_rec_t  push_rec;
  asa_pkg::frame_rec_t  top_rec;
  logic [CNTW-1:0]      frame_cnt;

  // input register
  logic                 in_vld_r;
  asa_pkg::in_word_t    in_word_r;
  logic                 adv;
  logic                 in_take;

  // result register
  logic                 out_vld_r;
  asa_pkg::out_word_t   out_word_r, res;

  // stack marker
  logic [SIZE_W-1:0]    used_r, used_nxt;

  // allocate datapath
  logic [CALC_W-1:0]    org, hdr, align_m1, data, pad, frame, need;
  logic                 full, no_mem;
  // free datapath
  logic [ADDR_W-1:0]    top_addr;
  logic [SIZE_W-1:0]    pop_bytes;

  asa_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  asa_frame_stack #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .push_rec (push_rec),
    .count    (frame_cnt),
    .top_rec  (top_rec)
  );

  // Work the held request when the result register is free or draining.
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_vld_r;
  assign out_data  = out_word_r;

  // Allocate: header sits at the marker rounded up to 8, data at
  // header + HEADER_BYTES rounded up to max(2^align_log2, MIN_ALIGN).
  assign org      = CALC_W'(cfg.base_address) + CALC_W'(used_r);
  assign hdr      = (org + CALC_W'(asa_pkg::HDR_ALIGN - 1)) & ~CALC_W'(asa_pkg::HDR_ALIGN - 1);
  assign align_m1 = ((CALC_W'(1) << in_word_r.align_log2) - CALC_W'(1))
                  | CALC_W'(asa_pkg::MIN_ALIGN - 1);
  assign data     = (hdr + CALC_W'(asa_pkg::HEADER_BYTES) + align_m1) & ~align_m1;
  assign pad      = data - org;
  assign frame    = pad + CALC_W'(in_word_r.alloc_bytes);
  assign need     = CALC_W'(used_r) + frame;
  assign no_mem   = need > CALC_W'(cfg.capacity);
  assign full     = frame_cnt >= CNTW'(MAX_FRAMES);

  // Free: only the top frame's data address pops it.
  assign top_addr  = cfg.base_address + ADDR_W'(top_rec.data);
  assign pop_bytes = used_r - top_rec.start;

  assign push_rec.start = used_r;
  assign push_rec.data  = SIZE_W'(data - CALC_W'(cfg.base_address));

  always_comb begin
    res        = '0;
    res.status = asa_pkg::ST_OK;
    used_nxt   = used_r;
    cmd        = '0;
    unique case (in_word_r.mode)
      asa_pkg::MODE_ALLOC: begin
        if (in_word_r.alloc_bytes == '0) begin
          res.status = asa_pkg::ST_ZERO;
        end else if (full) begin
          res.status = asa_pkg::ST_FULL;
        end else if (no_mem) begin
          res.status = asa_pkg::ST_NO_MEM;
        end else begin
          res.data_address = data[ADDR_W-1:0];
          res.frame_bytes  = frame[SIZE_W-1:0];
          used_nxt         = need[SIZE_W-1:0];
          cmd.push         = adv;
        end
      end
      asa_pkg::MODE_FREE: begin
        if (in_word_r.release_address == '0) begin
          res.status = asa_pkg::ST_OK;  // freeing null: no-op
        end else if (frame_cnt == '0) begin
          res.status = asa_pkg::ST_EMPTY;
        end else if (top_addr != in_word_r.release_address) begin
          res.status = asa_pkg::ST_NOT_TOP;
        end else begin
          res.frame_bytes = pop_bytes;
          used_nxt        = top_rec.start;
          cmd.pop         = adv;
        end
      end
      asa_pkg::MODE_CLEAR: begin
        used_nxt  = '0;
        cmd.clear = adv;
      end
      default: begin
        used_nxt = used_r;  // unused mode: report only
      end
    endcase
    res.used_bytes = used_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      used_r    <= '0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      out_vld_r <= adv || (out_vld_r && out_stall);
      if (adv) begin
        used_r <= used_nxt;
      end
    end
    if (in_take) begin
      in_word_r <= in_data;
    end
    if (adv) begin
      out_word_r <= res;
    end
  end

  `AST_NEXT(a_used_hold, !adv, $stable(used_r), "marker moved with no request worked")
  `AST_IMPLY(a_cmd_gated, cmd.push || cmd.pop || cmd.clear, adv, "stack touched without a request")
  `AST_IMPLY(a_back_press, in_vld_r && out_vld_r && out_stall, in_stall,
             "request worked into a stalled result register")
  `AST_IMPLY(a_err_zero, out_vld_r && out_word_r.status != asa_pkg::ST_OK,
             out_word_r.data_address == '0 && out_word_r.frame_bytes == '0,
             "failed request reports an address or size")

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking bench for the aligned LIFO stack allocator: drives requests, predicts results.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAMES = asa_pkg::MAX_FRAMES_DEF;
  localparam int ADDR_W = asa_pkg::ADDR_W;
  localparam int SIZE_W = asa_pkg::SIZE_W;
  localparam int CFG_ADDR_W = asa_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W = asa_pkg::CFG_DATA_W;
  // Mode 3 has no package name; the block must treat it as a no-op.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // Registers sit 8 bytes apart; the select bit is paddr[3].
  localparam logic [CFG_ADDR_W-1:0] ADDR_BASE     = {asa_pkg::REG_BASE_ADDR, 3'b000};
  localparam logic [CFG_ADDR_W-1:0] ADDR_CAPACITY = {asa_pkg::REG_CAPACITY, 3'b000};

  // Receiver stall behavior, re-picked whenever its random run length runs out.
  typedef enum int {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  // Allocator state as the bench tracks it: marker, frame depth, frame records.
  typedef struct packed {
    logic [SIZE_W-1:0]             used;
    logic [8:0]                    depth;
    logic [FRAMES-1:0][SIZE_W-1:0] start;
    logic [FRAMES-1:0][SIZE_W-1:0] doff;
  } stack_state_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  asa_pkg::in_word_t     in_data;
  logic                  out_valid;
  logic                  out_stall;
  asa_pkg::out_word_t    out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Register values as last written; both state copies use them.
  logic [ADDR_W-1:0] base_reg;
  logic [SIZE_W-1:0] cap_reg;

  // plan_st runs ahead as words are queued (so frees can target the top
  // frame); live_st advances only on accepted words and produces the
  // expected results.
  stack_state_t plan_st;
  stack_state_t live_st;

  asa_pkg::in_word_t  pending_requests[$];
  asa_pkg::out_word_t due_results[$];

  int errors      = 0;
  int words_in    = 0;
  int words_out   = 0;
  int max_depth   = 0;
  int settings    = 0;
  int status_seen[8];

  bit in_fire     = 1'b0;
  int burst_left  = 0;
  int gap_left    = 0;

  int       hold_left      = 0;
  int       mode_left      = 0;
  bit       long_hold_done = 1'b0;
  bit [3:0] rx_phase       = '0;
  rx_mode_t rx_mode        = RX_FLOW;

  aligned_stack_allocator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  function automatic logic [63:0] round_up(logic [63:0] x, logic [63:0] a);
    logic [63:0] r;
    r = x % a;
    return (r == 64'd0) ? x : x + (a - r);
  endfunction

  // Applies one request word to a state copy and returns the result word.
  function automatic asa_pkg::out_word_t apply_request(inout stack_state_t s,
                                                        input asa_pkg::in_word_t w);
    logic [63:0]        align;
    logic [63:0]        org;
    logic [63:0]        hdr;
    logic [63:0]        dptr;
    logic [63:0]        frame;
    logic [8:0]         top;
    logic [ADDR_W-1:0]  top_addr;
    asa_pkg::out_word_t r;
    r = '0;
    case (w.mode)
      asa_pkg::MODE_ALLOC: begin
        // zero size wins over a full record stack, which wins over no memory
        if (w.alloc_bytes == 0) begin
          r.status = asa_pkg::ST_ZERO;
        end else if (s.depth >= FRAMES) begin
          r.status = asa_pkg::ST_FULL;
        end else begin
          align = 64'd1 << w.align_log2;
          if (align < 64'(asa_pkg::MIN_ALIGN)) align = 64'(asa_pkg::MIN_ALIGN);
          org   = {16'd0, base_reg} + {32'd0, s.used};
          hdr   = round_up(org, 64'(asa_pkg::HDR_ALIGN));
          dptr  = round_up(hdr + 64'(asa_pkg::HEADER_BYTES), align);
          frame = (dptr - org) + {32'd0, w.alloc_bytes};
          if ({32'd0, s.used} + frame > {32'd0, cap_reg}) begin
            r.status = asa_pkg::ST_NO_MEM;
          end else begin
            s.start[s.depth[7:0]] = s.used;
            s.doff[s.depth[7:0]]  = dptr[31:0] - base_reg[31:0];
            s.depth               = s.depth + 9'd1;
            s.used                = s.used + frame[31:0];
            r.status              = asa_pkg::ST_OK;
            r.data_address        = dptr[ADDR_W-1:0];
            r.frame_bytes         = frame[31:0];
          end
        end
      end
      asa_pkg::MODE_FREE: begin
        // address zero is a silent no-op
        if (w.release_address != 0) begin
          if (s.depth == 0) begin
            r.status = asa_pkg::ST_EMPTY;
          end else begin
            top      = s.depth - 9'd1;
            top_addr = base_reg + {16'd0, s.doff[top[7:0]]};
            if (top_addr != w.release_address) begin
              r.status = asa_pkg::ST_NOT_TOP;
            end else begin
              r.frame_bytes = s.used - s.start[top[7:0]];
              s.used        = s.start[top[7:0]];
              s.depth       = top;
            end
          end
        end
      end
      asa_pkg::MODE_CLEAR: begin
        s.used  = '0;
        s.depth = '0;
      end
      default: ;
    endcase
    r.used_bytes = s.used;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Data address of the current top frame in the planned sequence.
  function automatic logic [ADDR_W-1:0] top_data_address();
    logic [8:0] t;
    t = plan_st.depth - 9'd1;
    return base_reg + {16'd0, plan_st.doff[t[7:0]]};
  endfunction

  task automatic put_word(logic [1:0] mode, logic [SIZE_W-1:0] nbytes, logic [3:0] alog,
                          logic [ADDR_W-1:0] rel);
    asa_pkg::in_word_t w;
    w.mode            = mode;
    w.alloc_bytes     = nbytes;
    w.align_log2      = alog;
    w.release_address = rel;
    void'(apply_request(plan_st, w));
    pending_requests.push_back(w);
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
  endtask

  // Two-phase register write; pready is tied high but is still honored.
  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // New register setting: the sender holds off until every result is back.
  task automatic set_config(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] cap);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_write(ADDR_BASE, {16'd0, base});
    base_reg = base;
    cfg_write(ADDR_CAPACITY, {32'd0, cap});
    cap_reg = cap;
    settings++;
  endtask

  // Mostly well-formed alloc/free traffic: frees usually hit the top frame,
  // the rest are out-of-order frees, no-op frees, clears and unused-mode noise.
  task automatic run_random(int count, int alloc_pct);
    int                pick;
    int                sel;
    logic [1:0]        mode;
    logic [SIZE_W-1:0] nbytes;
    logic [3:0]        alog;
    logic [ADDR_W-1:0] rel;
    logic [8:0]        idx;
    repeat (count) begin
      // untouched fields still carry random bits
      nbytes = $urandom;
      alog   = 4'($urandom);
      rel    = 48'({$urandom, $urandom});
      pick   = $urandom_range(0, 99);
      if (pick < alloc_pct) begin
        mode = asa_pkg::MODE_ALLOC;
        sel  = $urandom_range(0, 19);
        if (sel == 0)     nbytes = '0;
        else if (sel < 4) nbytes = $urandom_range(1, 4096);
        else if (sel > 4) nbytes = $urandom_range(1, 64);
        alog = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(13, 15))
                                           : 4'($urandom_range(0, 12));
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          mode = asa_pkg::MODE_FREE;
          if (plan_st.depth != 0) rel = top_data_address();
        end else if (sel < 82) begin
          mode = asa_pkg::MODE_FREE;
          idx  = plan_st.depth - 9'd2;
          if (plan_st.depth >= 2 && sel < 76)
            rel = base_reg + {16'd0, plan_st.doff[idx[7:0]]};
          else if (plan_st.depth != 0)
            rel = top_data_address() ^ (48'd1 << $urandom_range(0, ADDR_W - 1));
        end else if (sel < 88) begin
          mode = asa_pkg::MODE_FREE;
          rel  = '0;
        end else if (sel < 94) begin
          mode = asa_pkg::MODE_CLEAR;
        end else begin
          mode = MODE_UNUSED;
        end
      end
      put_word(mode, nbytes, alog, rel);
    end
  endtask

  // ---------------------------------------------------------------------
  // Request driver: bursts of random length, random gaps between them.
  // A word stays put until taken (in_fire is the previous edge's handshake).
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_requests.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_requests.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result stall pattern. One long hold after 300 words fills the pipe so
  // the block has to stall its input while the driver keeps offering.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    rx_phase <= rx_phase + 4'd1;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!long_hold_done && words_in >= 300) begin
      out_stall      <= 1'b1;
      hold_left      <= 150;
      long_hold_done <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(16, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_FLOW:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 99) < 25);
        RX_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
        default:  out_stall <= rx_phase[1] & rx_phase[0];
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: results checked against the oldest expectation; accepted
  // requests pushed through the predictor.
  // ---------------------------------------------------------------------
  task automatic check_result(asa_pkg::out_word_t got);
    asa_pkg::out_word_t want;
    if (due_results.size() == 0) begin
      $error("result word with nothing expected: status %0d addr %h", got.status,
             got.data_address);
      errors++;
    end else begin
      want = due_results.pop_front();
      status_seen[got.status]++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.data_address !== want.data_address) begin
        $error("data_address: expected %h, got %h", want.data_address, got.data_address);
        errors++;
      end
      if (got.frame_bytes !== want.frame_bytes) begin
        $error("frame_bytes: expected %0d, got %0d", want.frame_bytes, got.frame_bytes);
        errors++;
      end
      if (got.used_bytes !== want.used_bytes) begin
        $error("used_bytes: expected %0d, got %0d", want.used_bytes, got.used_bytes);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        check_result(out_data);
        words_out++;
      end
      if (in_valid && !in_stall) begin
        due_results.push_back(apply_request(live_st, in_data));
        words_in++;
        if (int'(live_st.depth) > max_depth) max_depth = int'(live_st.depth);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [ADDR_W-1:0] old_addr;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    out_stall = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    base_reg = '0;
    cap_reg  = asa_pkg::CAPACITY_RST;
    plan_st  = '0;
    live_st  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: edge fields, every mode, check order, large alignments.
    set_config(48'h0000_0000_1000, 32'd65536);
    put_word(asa_pkg::MODE_FREE, '0, '0, '0);           // free of zero on empty stack
    put_word(asa_pkg::MODE_FREE, '0, '0, '1);           // nonzero free on empty stack
    put_word(asa_pkg::MODE_ALLOC, '0, 4'd3, '0);        // zero size
    put_word(asa_pkg::MODE_ALLOC, 32'd1, 4'd0, '0);
    put_word(asa_pkg::MODE_ALLOC, 32'd100, 4'd12, '0);
    put_word(asa_pkg::MODE_ALLOC, 32'd200, 4'd15, '0);  // alignment past the nominal range
    put_word(asa_pkg::MODE_ALLOC, 32'd7, 4'd13, '0);
    put_word(asa_pkg::MODE_ALLOC, '1, 4'd0, '0);        // max size: out of memory
    put_word(asa_pkg::MODE_FREE, '0, '0, top_data_address() + 48'd8);  // not the top frame
    put_word(asa_pkg::MODE_FREE, '0, '0, top_data_address());
    put_word(asa_pkg::MODE_ALLOC, 32'd64, 4'd14, '0);
    put_word(MODE_UNUSED, '1, '1, '1);                  // unused mode, all fields high
    while (plan_st.depth != 0) put_word(asa_pkg::MODE_FREE, '0, '0, top_data_address());
    repeat (3) put_word(asa_pkg::MODE_ALLOC, 32'd24, 4'd4, '0);
    old_addr = top_data_address();
    put_word(asa_pkg::MODE_CLEAR, '1, '1, '1);
    put_word(asa_pkg::MODE_FREE, '0, '0, old_addr);     // stale address after a clear

    // Random phases over several register settings.
    set_config('0, 32'd65536);
    run_random(420, 50);
    // base near the top of the address space: data addresses wrap past 48 bits
    set_config(48'hFFFF_FFFF_FE00, '1);
    run_random(250, 50);
    // unaligned base with a tight capacity: frequent out of memory
    set_config(48'h0000_0012_3455, 32'd4000);
    run_random(250, 60);
    set_config(48'({$urandom, $urandom}) & ~48'h7, '0);
    run_random(60, 50);
    // alloc-heavy with room to spare: drives the record stack full
    set_config(48'({$urandom, $urandom}) & ~48'h7, 32'h0100_0000);
    run_random(330, 88);
    set_config(48'({$urandom, $urandom}), 32'($urandom_range(256, 1 << 20)));
    run_random(240, 55);

    wait_drained();
    repeat (8) @(posedge clk);
    if (due_results.size() != 0) begin
      $error("%0d expected result words never arrived", due_results.size());
      errors++;
    end

    $display("Ran %0d request words (%0d results) over %0d register settings,",
             words_in, words_out, settings);
    $display("stack depth up to %0d. Status mix: ok %0d, no-mem %0d, zero %0d, full %0d,",
             max_depth, status_seen[asa_pkg::ST_OK], status_seen[asa_pkg::ST_NO_MEM],
             status_seen[asa_pkg::ST_ZERO], status_seen[asa_pkg::ST_FULL]);
    $display("not-top %0d, empty %0d.",
             status_seen[asa_pkg::ST_NOT_TOP], status_seen[asa_pkg::ST_EMPTY]);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
